[sv/sector_overlay_table_top_assert.svh]
// assertion macros for the sector overlay table top level
`ifndef SECTOR_OVERLAY_TABLE_TOP_ASSERT_SVH
`define SECTOR_OVERLAY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, idle while rst_n is low
`define SOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, idle while rst_n is low
`define SOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sot_pkg.sv]
// shared types and constants for the sector overlay table
`default_nettype none

package sot_pkg;

  localparam int TABLE_ENTRIES    = 64;
  localparam int WORDS_PER_SECTOR = 64;

  localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int WORD_W  = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
  localparam int ADDR_W  = ENTRY_W + WORD_W;
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int SECTOR_W = 32;
  localparam int WIDX_W   = 6;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_ZERO = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input beat and register tag matches
    logic single;    // commit write effects and push one result beat
    logic stream;    // read one sector word and push it
  } sot_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;   // result pipe can take a beat this cycle
    logic is_read;
    logic hit;
    logic last_word;
  } sot_sts_t;

endpackage

`default_nettype wire

[sv/sot_ctrl.sv]
// controller state machine for the sector overlay table
`default_nettype none

module sot_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire sot_pkg::sot_sts_t sts,
  output sot_pkg::sot_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_STREAM = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no beat is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.advance) begin
          if (sts.is_read && sts.hit) begin
            state_nxt = S_STREAM;
          end else begin
            cmd.single = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_STREAM: begin
        if (sts.advance) begin
          cmd.stream = 1'b1;
          if (sts.last_word) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/sot_dp.sv]
// datapath: tag store, sector data memory and result pipe
`default_nettype none

module sot_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_mode,
  input  wire logic [sot_pkg::SECTOR_W-1:0]      in_sector,
  input  wire logic [sot_pkg::WIDX_W-1:0]        in_widx,
  input  wire logic [sot_pkg::DATA_W-1:0]        in_wword,
  input  wire sot_pkg::sot_cmd_t                 cmd,
  output sot_pkg::sot_sts_t                      sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [sot_pkg::STATUS_W-1:0]           out_status,
  output logic [sot_pkg::DATA_W-1:0]             out_word,
  output logic [sot_pkg::WIDX_W-1:0]             out_idx,
  output logic                                   out_last,
  output logic [sot_pkg::COUNT_W-1:0]            out_count
);

  localparam int DEPTH = 1 << sot_pkg::ADDR_W;

  // captured request
  logic                              mode_r;
  logic [sot_pkg::SECTOR_W-1:0]      sector_r;
  logic [sot_pkg::WIDX_W-1:0]        widx_r;
  logic [sot_pkg::DATA_W-1:0]        wword_r;

  // tag store
  logic [sot_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [sot_pkg::SECTOR_W-1:0]      tag_r [sot_pkg::TABLE_ENTRIES];
  logic [sot_pkg::TABLE_ENTRIES-1:0] match_r, match_nxt;
  logic [sot_pkg::USED_W-1:0]        used_r, used_nxt;

  logic                              hit;
  logic [sot_pkg::ENTRY_W-1:0]       hit_idx;
  logic                              full;
  logic                              alloc;
  logic                              upd;
  logic                              in_range;
  sot_pkg::status_t                  resp_status;

  // data memory
  logic [sot_pkg::DATA_W-1:0]        mem [DEPTH];
  logic                              wr_en;
  logic [sot_pkg::ADDR_W-1:0]        wr_addr;
  logic [sot_pkg::ADDR_W-1:0]        rd_addr;
  logic [sot_pkg::DATA_W-1:0]        rd_data_r;

  logic [sot_pkg::WORD_W-1:0]        cnt_r;
  logic                              last_word;

  // memory stage then output stage, both stall together
  logic                              advance;
  logic                              m_vld_r;
  logic [sot_pkg::STATUS_W-1:0]      m_status_r;
  logic [sot_pkg::WIDX_W-1:0]        m_idx_r;
  logic                              m_last_r;
  logic                              m_mem_r;
  logic [sot_pkg::COUNT_W-1:0]       m_count_r;

  logic                              out_valid_r;
  logic [sot_pkg::STATUS_W-1:0]      out_status_r;
  logic [sot_pkg::DATA_W-1:0]        out_word_r;
  logic [sot_pkg::WIDX_W-1:0]        out_idx_r;
  logic                              out_last_r;
  logic [sot_pkg::COUNT_W-1:0]       out_count_r;

  // parallel compare, registered
  always_comb begin
    for (int i = 0; i < sot_pkg::TABLE_ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == in_sector);
    end
  end

  // at most one match, so the encode is a plain or
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < sot_pkg::TABLE_ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | sot_pkg::ENTRY_W'(i);
      end
    end
  end

  assign hit       = |match_r;
  assign full      = (used_r == sot_pkg::USED_W'(sot_pkg::TABLE_ENTRIES));
  assign in_range  = (32'(widx_r) < sot_pkg::WORDS_PER_SECTOR);
  assign last_word = (cnt_r == sot_pkg::WORD_W'(sot_pkg::WORDS_PER_SECTOR - 1));
  assign advance   = !out_valid_r || out_ready;

  always_comb begin
    priority if (!mode_r) begin
      resp_status = sot_pkg::ST_MISS;
    end else if (hit) begin
      resp_status = sot_pkg::ST_OK;
    end else if (widx_r != '0) begin
      resp_status = sot_pkg::ST_NOT_ZERO;
    end else if (full) begin
      resp_status = sot_pkg::ST_FULL;
    end else begin
      resp_status = sot_pkg::ST_OK;
    end
  end

  assign alloc    = cmd.single && mode_r && !hit && (widx_r == '0) && !full;
  assign upd      = cmd.single && mode_r && hit && in_range;
  assign used_nxt = used_r + sot_pkg::USED_W'(alloc);

  assign wr_en   = alloc || upd;
  assign wr_addr = alloc ? {used_r[sot_pkg::ENTRY_W-1:0], sot_pkg::WORD_W'(0)}
                         : {hit_idx, widx_r[sot_pkg::WORD_W-1:0]};
  assign rd_addr = {hit_idx, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      sector_r <= in_sector;
      widx_r   <= in_widx;
      wword_r  <= in_wword;
      match_r  <= match_nxt;
    end
    if (alloc) begin
      tag_r[used_r[sot_pkg::ENTRY_W-1:0]] <= sector_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      if (alloc) begin
        valid_r[used_r[sot_pkg::ENTRY_W-1:0]] <= 1'b1;
      end
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wword_r;
    end
    if (cmd.stream) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.stream) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // result pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      m_vld_r     <= cmd.single || cmd.stream;
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cmd.single) begin
        m_status_r <= resp_status;
        m_idx_r    <= '0;
        m_last_r   <= 1'b1;
        m_mem_r    <= 1'b0;
        m_count_r  <= sot_pkg::COUNT_W'(used_nxt);
      end else begin
        m_status_r <= sot_pkg::ST_OK;
        m_idx_r    <= sot_pkg::WIDX_W'(cnt_r);
        m_last_r   <= last_word;
        m_mem_r    <= 1'b1;
        m_count_r  <= sot_pkg::COUNT_W'(used_r);
      end
      out_status_r <= m_status_r;
      out_word_r   <= m_mem_r ? rd_data_r : '0;
      out_idx_r    <= m_idx_r;
      out_last_r   <= m_last_r;
      out_count_r  <= m_count_r;
    end
  end

  assign sts.advance   = advance;
  assign sts.is_read   = !mode_r;
  assign sts.hit       = hit;
  assign sts.last_word = last_word;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_word   = out_word_r;
  assign out_idx    = out_idx_r;
  assign out_last   = out_last_r;
  assign out_count  = out_count_r;

endmodule

`default_nettype wire

[sv/sector_overlay_table_top.sv]
// top level of the sector overlay table
//
// copy-on-write overlay of disk sectors: up to 64 entries, each one sector
// number and 64 data words of 64 bits. one input beat is one request. a read
// (tuser 0) of a held sector returns all 64 words in order, the last beat
// with tlast; a read miss returns one beat with status miss. a write (tuser 1)
// stores one word into a held sector, or allocates a new entry when it names
// an absent sector at word zero; otherwise it returns table full or not at
// word zero and is dropped. every result beat carries the number of sectors
// held after the request. timing: a request is looked up in the cycle after
// its acceptance, against a registered compare of all tags, and no new
// request is taken until the last one has issued all its result beats.
// every result beat passes through the memory stage and the output stage of
// the result pipe. a read hit streams its 64 words from the single read port
// of the sector data memory, which gives one word per cycle; back-pressure
// on the result side stalls the word stream without loss. entries are never
// freed. valid bits are cleared at reset; the data memory needs no clearing
// pass, and a read of a word never written returns arbitrary data.
`default_nettype none

module sector_overlay_table_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // sector [31:0], word_index [37:32], write_word [101:38], zero pad
  input  wire logic [sot_pkg::IN_TDATA_W-1:0]      in_tdata,
  // mode
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // read_word [63:0], out_index [69:64], dirty_count [76:70], zero pad
  output logic [sot_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // status
  output logic [sot_pkg::STATUS_W-1:0]             out_tuser,
  output logic                                     out_tlast
);

  `include "sector_overlay_table_top_assert.svh"

  sot_pkg::sot_cmd_t cmd;
  sot_pkg::sot_sts_t sts;

  logic [sot_pkg::DATA_W-1:0]  res_word;
  logic [sot_pkg::WIDX_W-1:0]  res_idx;
  logic [sot_pkg::COUNT_W-1:0] res_count;

  // sequencing: accept, decide, stream words
  sot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tags, data memory and the two-stage result pipe
  sot_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_sector  (in_tdata[31:0]),
    .in_widx    (in_tdata[37:32]),
    .in_wword   (in_tdata[101:38]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_word   (res_word),
    .out_idx    (res_idx),
    .out_last   (out_tlast),
    .out_count  (res_count)
  );

  // pack result beat, pad to whole bytes
  assign out_tdata = {3'b000, res_count, res_idx, res_word};

  // one request at a time: no accept right after an accept
  `SOT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready,
    "input accepted twice in a row")

  // only a final beat may carry a non-ok status
  `SOT_ASSERT_NOW(a_error_is_last,
    out_tvalid && (out_tuser != sot_pkg::ST_OK), out_tlast,
    "error status on a beat that is not last")

  // the reported count never exceeds the table size
  `SOT_ASSERT_NOW(a_count_bound, out_tvalid,
    res_count <= sot_pkg::COUNT_W'(sot_pkg::TABLE_ENTRIES),
    "dirty count beyond table size")

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the sector overlay table top level
`timescale 1ns / 1ps

module testbench;
  import sot_pkg::*;

  // request kind, carried on in_tuser
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // one request beat as seen on the input stream
  typedef struct {
    op_t                 op;
    logic [SECTOR_W-1:0] sector;
    logic [WIDX_W-1:0]   widx;
    logic [DATA_W-1:0]   wdata;
  } overlay_req_t;

  // one result beat as seen on the output stream
  typedef struct {
    status_t            status;
    logic [DATA_W-1:0]  word;
    logic [WIDX_W-1:0]  index;
    logic               last;
    logic [COUNT_W-1:0] count;
  } sector_beat_t;

  // run length and traffic shaping
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;       // pipe is two stages deep, plenty of margin
  localparam int CALM_FROM    = 40;       // no idling on either side in this window
  localparam int CALM_TO      = 110;
  localparam int HOLD_AT      = 150;      // long result back-pressure starts here
  localparam int HOLD_CYCLES  = 400;
  localparam int FULL_SECTORS = 2;        // sectors written completely so reads can hit
  localparam int TAIL_ITEMS   = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  sector_overlay_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // requests waiting for the driver, and result beats waiting for the dut
  overlay_req_t request_q[$];
  sector_beat_t expected_beats[$];

  // stimulus-side bookkeeping: which sectors are held and which words written,
  // so that a read never touches a word that was never stored
  logic [SECTOR_W-1:0]         gen_sector[$];
  logic [WORDS_PER_SECTOR-1:0] gen_written [TABLE_ENTRIES];

  // overlay state as the checker sees it
  logic                ovl_valid  [TABLE_ENTRIES];
  logic [SECTOR_W-1:0] ovl_sector [TABLE_ENTRIES];
  logic [DATA_W-1:0]   ovl_data   [TABLE_ENTRIES][WORDS_PER_SECTOR];
  int                  ovl_used;

  // bookkeeping counters
  int cycle_cnt;
  int in_put_cnt;
  int in_done_cnt;
  int beats_seen;
  int mismatches;
  int n_hit, n_miss, n_alloc, n_update, n_full, n_not_zero;

  // long back-pressure state of the receiver
  bit hold_used;
  int hold_left;

  // ---------------------------------------------------------------------------
  // reporting
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // prediction: mirrors the overlay and queues the beats each request causes
  // ---------------------------------------------------------------------------

  task automatic push_beat(input status_t st, input logic [DATA_W-1:0] w,
                           input int idx, input logic lst);
    sector_beat_t b;
    b.status = st;
    b.word   = w;
    b.index  = WIDX_W'(idx);
    b.last   = lst;
    b.count  = COUNT_W'(ovl_used);
    expected_beats.push_back(b);
  endtask

  task automatic apply_request(input overlay_req_t rq);
    int hit_slot;
    hit_slot = -1;
    // lowest matching valid entry wins
    for (int e = TABLE_ENTRIES - 1; e >= 0; e--)
      if (ovl_valid[e] && ovl_sector[e] == rq.sector) hit_slot = e;

    if (rq.op == OP_READ) begin
      if (hit_slot < 0) begin
        n_miss++;
        push_beat(ST_MISS, '0, 0, 1'b1);
      end else begin
        n_hit++;
        for (int w = 0; w < WORDS_PER_SECTOR; w++)
          push_beat(ST_OK, ovl_data[hit_slot][w], w, w == WORDS_PER_SECTOR - 1);
      end
    end else if (hit_slot >= 0) begin
      n_update++;
      if (rq.widx < WORDS_PER_SECTOR) ovl_data[hit_slot][rq.widx] = rq.wdata;
      push_beat(ST_OK, '0, 0, 1'b1);
    end else if (rq.widx != 0) begin
      // nonzero index on an absent sector outranks a full table
      n_not_zero++;
      push_beat(ST_NOT_ZERO, '0, 0, 1'b1);
    end else if (ovl_used >= TABLE_ENTRIES) begin
      n_full++;
      push_beat(ST_FULL, '0, 0, 1'b1);
    end else begin
      n_alloc++;
      ovl_valid[ovl_used]     = 1'b1;
      ovl_sector[ovl_used]    = rq.sector;
      ovl_data[ovl_used][0]   = rq.wdata;
      ovl_used++;
      push_beat(ST_OK, '0, 0, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int held_slot(input logic [SECTOR_W-1:0] s);
    for (int i = 0; i < gen_sector.size(); i++)
      if (gen_sector[i] == s) return i;
    return -1;
  endfunction

  function automatic logic [SECTOR_W-1:0] fresh_sector();
    logic [SECTOR_W-1:0] s;
    s = $urandom;
    while (held_slot(s) >= 0) s = $urandom;
    return s;
  endfunction

  // a held sector whose every word has been written, or -1
  function automatic int complete_slot();
    int cand[$];
    for (int i = 0; i < gen_sector.size(); i++)
      if (&gen_written[i]) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_req(input op_t op, input logic [SECTOR_W-1:0] s,
                           input logic [WIDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    int slot;
    overlay_req_t rq;
    slot = held_slot(s);
    if (op == OP_WRITE) begin
      if (slot >= 0) begin
        gen_written[slot][idx] = 1'b1;
      end else if (idx == 0 && gen_sector.size() < TABLE_ENTRIES) begin
        gen_sector.push_back(s);
        gen_written[gen_sector.size() - 1] = WORDS_PER_SECTOR'(1);
      end
    end
    rq.op     = op;
    rq.sector = s;
    rq.widx   = idx;
    rq.wdata  = d;
    request_q.push_back(rq);
  endtask

  // one request of random kind; reads only go to complete or absent sectors
  task automatic add_noise();
    int pick;
    int slot;
    pick = $urandom_range(99);
    slot = complete_slot();
    if (pick < 25 && slot >= 0)
      queue_req(OP_READ, gen_sector[slot], WIDX_W'($urandom), rand_word());
    else if (pick < 45)
      queue_req(OP_READ, fresh_sector(), WIDX_W'($urandom), rand_word());
    else if (pick < 65)
      queue_req(OP_WRITE, fresh_sector(),
                WIDX_W'($urandom_range(WORDS_PER_SECTOR - 1, 1)), rand_word());
    else if (pick < 85 && gen_sector.size() > 0)
      queue_req(OP_WRITE, gen_sector[$urandom_range(gen_sector.size() - 1)],
                WIDX_W'($urandom_range(WORDS_PER_SECTOR - 1)), rand_word());
    else
      queue_req(OP_WRITE, fresh_sector(), WIDX_W'(0), rand_word());   // allocate, or full
  endtask

  // sender and receiver pause at random, except inside the calm window
  function automatic bit take_break();
    if (in_done_cnt >= CALM_FROM && in_done_cnt < CALM_TO) return 1'b0;
    return $urandom_range(99) < 24;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one beat at a time from request_q, changes on falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n && in_done_cnt == in_put_cnt) begin
      // bus is free: previous beat was taken, or nothing was offered
      if (request_q.size() > 0 && !take_break()) begin
        overlay_req_t rq;
        rq = request_q.pop_front();
        in_tdata  <= {{(IN_TDATA_W - SECTOR_W - WIDX_W - DATA_W){1'b0}},
                      rq.wdata, rq.widx, rq.sector};
        in_tuser  <= rq.op;
        in_tvalid <= 1'b1;
        in_put_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_used && in_done_cnt >= HOLD_AT) begin
        // sender keeps offering, so the dut fills up and drops in_tready
        hold_used  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !take_break();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result beats, then feeds accepted requests to the mirror
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    sector_beat_t got;
    sector_beat_t want;
    overlay_req_t rq;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.word   = out_tdata[DATA_W-1:0];
        got.index  = out_tdata[DATA_W +: WIDX_W];
        got.last   = out_tlast;
        got.count  = out_tdata[DATA_W + WIDX_W +: COUNT_W];
        beats_seen++;
        if (expected_beats.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d with nothing expected", beats_seen));
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status)
            flag_mismatch($sformatf("beat %0d status got %0d exp %0d",
                                    beats_seen, got.status, want.status));
          if (got.word !== want.word)
            flag_mismatch($sformatf("beat %0d read_word got %h exp %h",
                                    beats_seen, got.word, want.word));
          if (got.index !== want.index)
            flag_mismatch($sformatf("beat %0d out_index got %0d exp %0d",
                                    beats_seen, got.index, want.index));
          if (got.last !== want.last)
            flag_mismatch($sformatf("beat %0d tlast got %b exp %b",
                                    beats_seen, got.last, want.last));
          if (got.count !== want.count)
            flag_mismatch($sformatf("beat %0d dirty_count got %0d exp %0d",
                                    beats_seen, got.count, want.count));
        end
      end
      // requests are predicted from the bus, exactly as the dut took them
      if (in_tvalid && in_tready) begin
        rq.op     = op_t'(in_tuser);
        rq.sector = in_tdata[SECTOR_W-1:0];
        rq.widx   = in_tdata[SECTOR_W +: WIDX_W];
        rq.wdata  = in_tdata[SECTOR_W + WIDX_W +: DATA_W];
        apply_request(rq);
        in_done_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_cnt, expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int order[WORDS_PER_SECTOR-1];
    int j, tmp;
    logic [SECTOR_W-1:0] s;

    for (int e = 0; e < TABLE_ENTRIES; e++) ovl_valid[e] = 1'b0;

    // directed: empty-table misses, rejections, allocations at extremes
    queue_req(OP_READ,  32'h0000_0000, '0, '0);                    // miss on empty table
    queue_req(OP_READ,  32'hFFFF_FFFF, '1, '1);                    // miss, unused fields high
    queue_req(OP_WRITE, 32'h0000_0000, 6'd63, '1);                 // absent, not at word zero
    queue_req(OP_WRITE, 32'hFFFF_FFFF, 6'd1, rand_word());         // absent, not at word zero
    queue_req(OP_WRITE, 32'h0000_0000, 6'd0, '0);                  // allocate first entry
    queue_req(OP_WRITE, 32'hFFFF_FFFF, 6'd0, '1);                  // allocate second entry
    queue_req(OP_WRITE, 32'h0000_0000, 6'd63, '1);                 // update held sector, top word
    queue_req(OP_WRITE, 32'hFFFF_FFFF, 6'd63, '0);
    queue_req(OP_READ,  32'h0000_0001, '0, '0);                    // neighbour of a held sector
    queue_req(OP_WRITE, 32'h0000_0000, 6'd0, 64'hA5A5_5A5A_F00F_0FF0); // word zero of held sector
    queue_req(OP_READ,  32'h8000_0000, 6'd32, rand_word());        // miss
    queue_req(OP_WRITE, 32'h8000_0000, 6'd32, rand_word());        // absent, mid index
    queue_req(OP_WRITE, 32'h7FFF_FFFF, 6'd0, 64'h8000_0000_0000_0001); // allocate

    // fill whole sectors in shuffled word order so reads can hit
    for (int k = 0; k < FULL_SECTORS; k++) begin
      s = fresh_sector();
      queue_req(OP_WRITE, s, 6'd0, rand_word());
      for (int i = 0; i < WORDS_PER_SECTOR - 1; i++) order[i] = i + 1;
      for (int i = WORDS_PER_SECTOR - 2; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < WORDS_PER_SECTOR - 1; i++) begin
        if ($urandom_range(99) < 25) add_noise();
        queue_req(OP_WRITE, s, WIDX_W'(order[i]), rand_word());
      end
      queue_req(OP_READ, s, WIDX_W'($urandom), rand_word());       // read back, full hit
    end

    // grow the table to its limit with noise mixed in
    while (gen_sector.size() < TABLE_ENTRIES) begin
      if ($urandom_range(99) < 70) queue_req(OP_WRITE, fresh_sector(), WIDX_W'(0), rand_word());
      else add_noise();
    end

    // table full: allocation refused, nonzero index still reported as such
    queue_req(OP_WRITE, fresh_sector(), 6'd0, rand_word());
    queue_req(OP_WRITE, fresh_sector(), 6'd5, rand_word());
    for (int i = 0; i < TAIL_ITEMS; i++) add_noise();

    // single reset pulse
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request to go in and every result beat to come out
    while (request_q.size() > 0 || in_done_cnt != in_put_cnt || expected_beats.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_beats.size() > 0)
      flag_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));

    $display("run covered %0d requests: %0d read hits, %0d read misses, %0d allocations,",
             in_done_cnt, n_hit, n_miss, n_alloc);
    $display("  %0d word updates, %0d full and %0d nonzero-index rejections, %0d beats checked",
             n_update, n_full, n_not_zero, beats_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
